FILE: hw/rtl/binary_conv3x3_line_buffer_unit_assert.svh
// Assertion macros shared by the convolution unit.
// Each macro takes a label, an antecedent and a consequent, clocked on clk
// and disabled while rst is high.
`ifndef BINARY_CONV3X3_LINE_BUFFER_UNIT_ASSERT_SVH
`define BINARY_CONV3X3_LINE_BUFFER_UNIT_ASSERT_SVH

// Same-cycle implication.
`define BCL_ASSERT_IMPL(name, ante, cons) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed");

// Next-cycle implication.
`define BCL_ASSERT_NEXT(name, ante, cons) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

FILE: hw/rtl/bcl_pkg.sv
// ----------------------------------------------------------------------------
// bcl_pkg: shared types and constants
// Register indexes, reset values, window masks, queue sizing and the command
// and status records passed between the front and back parts.
// ----------------------------------------------------------------------------
package bcl_pkg;

  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 9;

  localparam logic [CFG_IDX_W-1:0] REG_KERNEL    = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_THRESHOLD = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_POLARITY  = 2'd2;

  localparam int WIN_N   = 9;
  localparam int COUNT_W = 4;

  localparam logic [WIN_N-1:0]   KERNEL_RESET    = 9'd123;
  localparam logic [COUNT_W-1:0] THRESHOLD_RESET = 4'd6;
  localparam logic               POLARITY_RESET  = 1'b1;

  // Window positions, row-major, bit 0 is top-left.
  localparam logic [WIN_N-1:0] TOP_ROW_MASK   = 9'h007;
  localparam logic [WIN_N-1:0] BOT_ROW_MASK   = 9'h1C0;
  localparam logic [WIN_N-1:0] LEFT_COL_MASK  = 9'h049;
  localparam logic [WIN_N-1:0] RIGHT_COL_MASK = 9'h124;

  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W      = 2;
  localparam int QCNT_W      = 3;

  typedef struct packed {
    logic [WIN_N-1:0]   kernel;
    logic [COUNT_W-1:0] threshold;
    logic               polarity;
  } cfg_t;

  typedef enum logic {
    CMD_PIXEL = 1'b0,
    CMD_FLUSH = 1'b1
  } cmd_kind_t;

  typedef struct packed {
    cmd_kind_t kind;
    logic      pixel;
  } cmd_t;

  typedef struct packed {
    logic valid;
    cmd_t cmd;
  } q_head_t;

  typedef struct packed {
    logic flushing;
    logic held_valid;
  } eng_status_t;

  function automatic logic [COUNT_W-1:0] popcount9(input logic [WIN_N-1:0] v);
    logic [COUNT_W-1:0] acc;
    acc = '0;
    for (int k = 0; k < WIN_N; k++) begin
      acc = acc + COUNT_W'(v[k]);
    end
    return acc;
  endfunction

endpackage

FILE: hw/rtl/bcl_in_if.sv
// ----------------------------------------------------------------------------
// bcl_in_if: pixel input channel
// Valid/ready channel carrying one pixel bit and the frame-end flag per item.
// ----------------------------------------------------------------------------
interface bcl_in_if;
  logic valid;
  logic ready;
  logic pixel;
  logic frame_end;

  modport source(output valid, output pixel, output frame_end, input ready);
  modport sink(input valid, input pixel, input frame_end, output ready);
endinterface

FILE: hw/rtl/bcl_out_if.sv
// ----------------------------------------------------------------------------
// bcl_out_if: result output channel
// Valid/ready channel carrying one thresholded convolution result per item.
// ----------------------------------------------------------------------------
interface bcl_out_if;
  logic       valid;
  logic       ready;
  logic       bit_out;
  logic [3:0] match_count;
  logic       last;

  modport source(output valid, output bit_out, output match_count, output last,
                 input ready);
  modport sink(input valid, input bit_out, input match_count, input last,
               output ready);
endinterface

FILE: hw/rtl/binary_conv3x3_line_buffer_unit.sv
// ----------------------------------------------------------------------------
// binary_conv3x3_line_buffer_unit: streaming binary 3x3 convolution
// Zero-padded XNOR-popcount convolution over a raster-order binary image with
// a thresholded one-bit result per pixel.
// ----------------------------------------------------------------------------
// Pixels enter one bit per item in raster order, and each result item is
// centered on the pixel of the same row and column, so results trail the
// input by IMG_WIDTH+1 items. Window positions outside the image count as 0;
// match_count is the number of positions where the window equals the kernel
// and bit_out compares it with the threshold (at least it when polarity is 1,
// at most it when polarity is 0). The engine takes one item per clock cycle
// while the result register drains and no flush or held result is pending.
// An item flagged frame_end starts a flush that shifts in zero padding and
// emits the pending results; the four-entry input queue keeps accepting
// items until it fills. The final result of a frame, marked last, is held
// and released when the next item reaches the engine. Configuration writes
// take effect on the next cycle and are meant for idle periods.
module binary_conv3x3_line_buffer_unit #(
  parameter int IMG_WIDTH  = 24,
  parameter int IMG_HEIGHT = 24
) (
  input  logic                           clk,
  input  logic                           rst,
  bcl_in_if.sink                         pixels,
  bcl_out_if.source                      results,
  input  logic                           cfg_we,
  input  logic [bcl_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [bcl_pkg::CFG_DATA_W-1:0] cfg_data
);

  `include "binary_conv3x3_line_buffer_unit_assert.svh"

  bcl_pkg::cfg_t        cfg;
  bcl_pkg::q_head_t     head;
  bcl_pkg::eng_status_t st;
  logic                 q_pop;

  // Configuration registers; writes to unused indexes are dropped.
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.kernel    <= bcl_pkg::KERNEL_RESET;
      cfg.threshold <= bcl_pkg::THRESHOLD_RESET;
      cfg.polarity  <= bcl_pkg::POLARITY_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        bcl_pkg::REG_KERNEL:    cfg.kernel    <= cfg_data;
        bcl_pkg::REG_THRESHOLD: cfg.threshold <= cfg_data[bcl_pkg::COUNT_W-1:0];
        bcl_pkg::REG_POLARITY:  cfg.polarity  <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // The front queues and tags incoming items.
  bcl_front u_front (
    .clk    (clk),
    .rst    (rst),
    .pixels (pixels),
    .head   (head),
    .pop    (q_pop)
  );

  // The engine runs the line buffers, window, flush and result register.
  bcl_engine #(
    .IMG_WIDTH  (IMG_WIDTH),
    .IMG_HEIGHT (IMG_HEIGHT)
  ) u_engine (
    .clk     (clk),
    .rst     (rst),
    .cfg     (cfg),
    .head    (head),
    .pop     (q_pop),
    .results (results),
    .status  (st)
  );

  // A held final result never coexists with an active flush.
  `BCL_ASSERT_IMPL(a_held_not_flushing, st.flushing, !st.held_valid)
  // A flush only begins after the engine took a frame-ending item.
  `BCL_ASSERT_IMPL(a_flush_starts_on_frame_end, $rose(st.flushing),
                   $past(q_pop && (head.cmd.kind == bcl_pkg::CMD_FLUSH)))
  // With an item waiting and room at the output, a held result goes out next.
  `BCL_ASSERT_NEXT(a_held_released,
                   st.held_valid && head.valid && (!results.valid || results.ready),
                   results.valid && results.last)
  // The count can never exceed the window size.
  `BCL_ASSERT_IMPL(a_count_range, results.valid, results.match_count <= 4'd9)

endmodule

FILE: hw/rtl/bcl_front.sv
// ----------------------------------------------------------------------------
// bcl_front: input side of the convolution unit
// Accepts pixel items, tags each as a plain pixel or a frame-ending pixel,
// and keeps them in a short queue for the engine.
// ----------------------------------------------------------------------------
module bcl_front (
  input  logic             clk,
  input  logic             rst,
  bcl_in_if.sink           pixels,
  output bcl_pkg::q_head_t head,
  input  logic             pop
);

  bcl_pkg::cmd_t                  entries [bcl_pkg::QUEUE_DEPTH];
  logic [bcl_pkg::QPTR_W-1:0]     rd_ptr;
  logic [bcl_pkg::QPTR_W-1:0]     wr_ptr;
  logic [bcl_pkg::QCNT_W-1:0]     count;
  logic                           push;
  logic                           pop_ok;
  bcl_pkg::cmd_t                  incoming;

  assign pixels.ready = (count != bcl_pkg::QCNT_W'(bcl_pkg::QUEUE_DEPTH));
  assign push         = pixels.valid && pixels.ready;
  assign pop_ok       = pop && (count != '0);

  always_comb begin
    incoming.kind  = pixels.frame_end ? bcl_pkg::CMD_FLUSH : bcl_pkg::CMD_PIXEL;
    incoming.pixel = pixels.pixel;
  end

  assign head.valid = (count != '0);
  assign head.cmd   = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= incoming;
    end
    if (rst) begin
      rd_ptr <= '0;
      wr_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + bcl_pkg::QPTR_W'(1);
      end
      if (pop_ok) begin
        rd_ptr <= rd_ptr + bcl_pkg::QPTR_W'(1);
      end
      case ({push, pop_ok})
        2'b10:   count <= count + bcl_pkg::QCNT_W'(1);
        2'b01:   count <= count - bcl_pkg::QCNT_W'(1);
        default: count <= count;
      endcase
    end
  end

endmodule

FILE: hw/rtl/bcl_engine.sv
// ----------------------------------------------------------------------------
// bcl_engine: line buffers, window and result stage
// Shifts pixels through two line buffers and a 3x3 window, scores the
// zero-padded window against the kernel, flushes pending results at frame
// end and drives the registered result channel.
// ----------------------------------------------------------------------------
module bcl_engine #(
  parameter int IMG_WIDTH  = 24,
  parameter int IMG_HEIGHT = 24
) (
  input  logic                 clk,
  input  logic                 rst,
  input  bcl_pkg::cfg_t        cfg,
  input  bcl_pkg::q_head_t     head,
  output logic                 pop,
  bcl_out_if.source            results,
  output bcl_pkg::eng_status_t status
);

  localparam int ROW_W  = $clog2(IMG_HEIGHT);
  localparam int COL_W  = $clog2(IMG_WIDTH);
  localparam int SEEN_W = $clog2(IMG_WIDTH + 2);

  localparam logic [ROW_W-1:0]  LAST_ROW  = ROW_W'(IMG_HEIGHT - 1);
  localparam logic [COL_W-1:0]  LAST_COL  = COL_W'(IMG_WIDTH - 1);
  localparam logic [SEEN_W-1:0] SEEN_FULL = SEEN_W'(IMG_WIDTH + 1);
  localparam logic [SEEN_W-1:0] ONE_LEFT  = SEEN_W'(1);

  typedef enum logic {
    ST_RUN   = 1'b0,
    ST_FLUSH = 1'b1
  } state_t;

  state_t                       state;
  logic [IMG_WIDTH-1:0]         upper_line;
  logic [IMG_WIDTH-1:0]         middle_line;
  logic [bcl_pkg::WIN_N-1:0]    window_regs;
  logic [ROW_W-1:0]             out_row;
  logic [COL_W-1:0]             out_col;
  logic [SEEN_W-1:0]            pixels_seen;
  logic [SEEN_W-1:0]            flush_left;
  logic                         held_valid;
  logic                         held_bit;
  logic [bcl_pkg::COUNT_W-1:0]  held_count;

  logic                         out_valid;
  logic                         out_bit;
  logic [bcl_pkg::COUNT_W-1:0]  out_count;
  logic                         out_last;

  logic                         can_write;
  logic                         run_held;
  logic                         run_pixel;
  logic                         flush_step;
  logic                         seen_full;
  logic                         final_step;
  logic                         emit_eval;
  logic                         shift_px;
  logic [SEEN_W-1:0]            seen_next;
  logic [bcl_pkg::WIN_N-1:0]    window_next;
  logic [bcl_pkg::WIN_N-1:0]    pad_mask;
  logic [bcl_pkg::WIN_N-1:0]    eq_bits;
  logic [bcl_pkg::COUNT_W-1:0]  eval_count;
  logic                         eval_bit;
  logic [ROW_W-1:0]             row_next;
  logic [COL_W-1:0]             col_next;

  assign can_write  = !out_valid || results.ready;
  assign run_held   = (state == ST_RUN) && head.valid && held_valid && can_write;
  assign run_pixel  = (state == ST_RUN) && head.valid && !held_valid && can_write;
  assign flush_step = (state == ST_FLUSH) && can_write;
  assign seen_full  = (pixels_seen == SEEN_FULL);
  assign final_step = flush_step && (flush_left == ONE_LEFT);
  assign emit_eval  = (run_pixel && seen_full) || (flush_step && !final_step);
  assign pop        = run_pixel;

  // Zeros are shifted in during a flush; they act as padding past the frame.
  assign shift_px  = (state == ST_RUN) ? head.cmd.pixel : 1'b0;
  assign seen_next = seen_full ? SEEN_FULL : pixels_seen + SEEN_W'(1);

  assign window_next = {shift_px, window_regs[8:7], middle_line[IMG_WIDTH-1],
                        window_regs[5:4], upper_line[IMG_WIDTH-1],
                        window_regs[2:1]};

  always_comb begin
    pad_mask = '1;
    if (out_row == '0) begin
      pad_mask = pad_mask & ~bcl_pkg::TOP_ROW_MASK;
    end
    if (out_row == LAST_ROW) begin
      pad_mask = pad_mask & ~bcl_pkg::BOT_ROW_MASK;
    end
    if (out_col == '0) begin
      pad_mask = pad_mask & ~bcl_pkg::LEFT_COL_MASK;
    end
    if (out_col == LAST_COL) begin
      pad_mask = pad_mask & ~bcl_pkg::RIGHT_COL_MASK;
    end
  end

  assign eq_bits    = ~((window_next & pad_mask) ^ cfg.kernel);
  assign eval_count = bcl_pkg::popcount9(eq_bits);
  assign eval_bit   = cfg.polarity ? (eval_count >= cfg.threshold)
                                   : (eval_count <= cfg.threshold);

  always_comb begin
    if (out_col >= LAST_COL) begin
      col_next = '0;
      row_next = (out_row >= LAST_ROW) ? '0 : out_row + ROW_W'(1);
    end else begin
      col_next = out_col + COL_W'(1);
      row_next = out_row;
    end
  end

  always_ff @(posedge clk) begin
    if (can_write) begin
      out_bit   <= run_held ? held_bit : eval_bit;
      out_count <= run_held ? held_count : eval_count;
      out_last  <= run_held;
    end
    if (final_step) begin
      held_bit   <= eval_bit;
      held_count <= eval_count;
    end
    if (rst) begin
      state       <= ST_RUN;
      upper_line  <= '0;
      middle_line <= '0;
      window_regs <= '0;
      out_row     <= '0;
      out_col     <= '0;
      pixels_seen <= '0;
      flush_left  <= '0;
      held_valid  <= 1'b0;
      out_valid   <= 1'b0;
    end else begin
      if (can_write) begin
        out_valid <= run_held || emit_eval;
      end
      if (run_held) begin
        held_valid <= 1'b0;
      end
      if (run_pixel || flush_step) begin
        upper_line  <= {upper_line[IMG_WIDTH-2:0], middle_line[IMG_WIDTH-1]};
        middle_line <= {middle_line[IMG_WIDTH-2:0], shift_px};
        window_regs <= window_next;
      end
      if (run_pixel) begin
        pixels_seen <= seen_next;
        if (seen_full) begin
          out_row <= row_next;
          out_col <= col_next;
        end
        if (head.cmd.kind == bcl_pkg::CMD_FLUSH) begin
          flush_left <= seen_next;
          state      <= ST_FLUSH;
        end
      end
      if (flush_step) begin
        if (final_step) begin
          held_valid  <= 1'b1;
          out_row     <= '0;
          out_col     <= '0;
          pixels_seen <= '0;
          flush_left  <= '0;
          state       <= ST_RUN;
        end else begin
          out_row    <= row_next;
          out_col    <= col_next;
          flush_left <= flush_left - SEEN_W'(1);
        end
      end
    end
  end

  assign results.valid       = out_valid;
  assign results.bit_out     = out_bit;
  assign results.match_count = out_count;
  assign results.last        = out_last;

  assign status.flushing   = (state == ST_FLUSH);
  assign status.held_valid = held_valid;

endmodule
